// ----- design/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define AKSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define AKSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/akscp_pkg.sv -----
// ---------------------------------------------------------------------------
// akscp_pkg
// Shared types and constants of the additive key stream byte cipher.
// ---------------------------------------------------------------------------
package akscp_pkg;

    localparam int BYTE_W      = 8;
    localparam int GROUP_SIZE  = 3;
    localparam int GP_W        = $clog2(GROUP_SIZE + 1);
    localparam int KEY_COUNT   = 5;
    localparam int ROLL_TOP    = 3;
    localparam int KIDX_W      = 3;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_W   = 3;

    localparam logic [BYTE_W-1:0] FILLER_BYTE = 8'h2A;

    // Register map, byte address = 4 * index
    localparam logic [REG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DECRYPT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY0    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY1    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KEY2    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_KEY3    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_KEY4    = 3'd7;

    typedef enum logic [1:0] {
        MODE_FIXED = 2'd0,
        MODE_ROLL  = 2'd1,
        MODE_KEYS  = 2'd2,
        MODE_FILL  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                              mode;
        logic                               decrypt;
        logic [BYTE_W-1:0]                  shift_amount;
        logic [KEY_COUNT-1:0][BYTE_W-1:0]   key;
    } cfg_t;

    // Results of one byte, handed to the result buffer
    typedef struct packed {
        logic              valid;
        logic [1:0]        count;
        logic [BYTE_W-1:0] data0;
        logic              last0;
        logic [BYTE_W-1:0] data1;
        logic              last1;
    } push_t;

endpackage

// ----- design/akscp_regs.sv -----
// ---------------------------------------------------------------------------
// akscp_regs
// APB register file: mode, direction, fixed shift and the five keys.
// ---------------------------------------------------------------------------
module akscp_regs
    import akscp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx) inside
                REG_MODE:    cfg_next.mode         = mode_t'(pwdata[1:0]);
                REG_DECRYPT: cfg_next.decrypt      = pwdata[0];
                REG_SHIFT:   cfg_next.shift_amount = pwdata[BYTE_W-1:0];
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3, REG_KEY4: begin
                    cfg_next.key[KIDX_W'(reg_idx - REG_KEY0)] = pwdata[BYTE_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx) inside
            REG_MODE:    prdata[1:0]        = cfg_reg.mode;
            REG_DECRYPT: prdata[0]          = cfg_reg.decrypt;
            REG_SHIFT:   prdata[BYTE_W-1:0] = cfg_reg.shift_amount;
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3, REG_KEY4: begin
                prdata[BYTE_W-1:0] = cfg_reg.key[KIDX_W'(reg_idx - REG_KEY0)];
            end
        endcase
    end

endmodule

// ----- design/akscp_xform.sv -----
// ---------------------------------------------------------------------------
// akscp_xform
// Input register, shift selection and stream position counters.
// ---------------------------------------------------------------------------
module akscp_xform
    import akscp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              s_in_last,
    input  logic              room,
    output push_t             push
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_last_reg;
    logic [GP_W-1:0]   gp_reg;
    logic [GP_W-1:0]   gp_next;
    logic [KIDX_W-1:0] kidx_reg;
    logic [KIDX_W-1:0] kidx_next;

    logic [KIDX_W-1:0] kidx_key;
    logic [KIDX_W-1:0] kidx_key_nx;
    logic [KIDX_W-1:0] kidx_roll;
    logic [KIDX_W-1:0] kidx_roll_nx;
    logic [BYTE_W-1:0] shift;
    logic              grp_full;
    logic              grp_over;
    logic              fire;

    assign fire    = in_valid_reg & room;
    assign s_ready = ~in_valid_reg | room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_in_last;
        end
    end

    always_comb begin
        // clamp stale indexes left over from another mode
        kidx_key  = (kidx_reg < KIDX_W'(KEY_COUNT)) ? kidx_reg : KIDX_W'(KEY_COUNT - 1);
        kidx_roll = (kidx_reg < KIDX_W'(ROLL_TOP)) ? kidx_reg : KIDX_W'(ROLL_TOP - 1);
        kidx_key_nx  = (kidx_key == KIDX_W'(KEY_COUNT - 1)) ? '0 : kidx_key + 1'b1;
        kidx_roll_nx = (kidx_roll == KIDX_W'(ROLL_TOP - 1)) ? '0 : kidx_roll + 1'b1;
        grp_full = ({1'b0, gp_reg} + 1'b1) >= (GP_W + 1)'(GROUP_SIZE);
        grp_over = gp_reg >= GP_W'(GROUP_SIZE);

        shift      = cfg.shift_amount;
        kidx_next  = kidx_reg;
        gp_next    = gp_reg;
        push.count = 2'd1;
        push.last0 = in_last_reg;
        push.data1 = FILLER_BYTE;
        push.last1 = in_last_reg;

        case (cfg.mode)
            MODE_FIXED: ;
            MODE_ROLL: begin
                shift     = BYTE_W'(kidx_roll) + 1'b1;
                kidx_next = kidx_roll_nx;
            end
            MODE_KEYS: begin
                shift     = cfg.key[kidx_key];
                kidx_next = kidx_key_nx;
            end
            MODE_FILL: begin
                shift = cfg.key[kidx_key];
                if (!cfg.decrypt) begin
                    kidx_next = kidx_key_nx;
                    if (grp_full) begin
                        // group complete: append the filler, it carries the last mark
                        gp_next    = '0;
                        push.count = 2'd2;
                        push.last0 = 1'b0;
                    end else begin
                        gp_next = gp_reg + 1'b1;
                    end
                end else if (grp_over) begin
                    // drop the filler, key stays put
                    gp_next    = '0;
                    push.count = 2'd0;
                end else begin
                    gp_next   = gp_reg + 1'b1;
                    kidx_next = kidx_key_nx;
                end
            end
            default: ;
        endcase

        if (in_last_reg) begin
            gp_next   = '0;
            kidx_next = '0;
        end

        push.valid = fire;
        push.data0 = cfg.decrypt ? in_data_reg - shift : in_data_reg + shift;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gp_reg   <= '0;
            kidx_reg <= '0;
        end else if (fire) begin
            gp_reg   <= gp_next;
            kidx_reg <= kidx_next;
        end
    end

endmodule

// ----- design/akscp_obuf.sv -----
// ---------------------------------------------------------------------------
// akscp_obuf
// Two-entry result buffer; takes all results of one byte at once.
// ---------------------------------------------------------------------------
module akscp_obuf
    import akscp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  push_t             push,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_out_last
);

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic [BYTE_W-1:0] data0_reg;
    logic [BYTE_W-1:0] data1_reg;
    logic              last0_reg;
    logic              last1_reg;
    logic              pop;

    assign m_valid    = count_reg != 2'd0;
    assign m_out_byte = data0_reg;
    assign m_out_last = last0_reg;
    assign pop        = m_valid & m_ready;
    // buffer is empty once this cycle's request leaves
    assign room       = (count_reg == 2'd0) | ((count_reg == 2'd1) & m_ready);

    always_comb begin
        count_next = count_reg - {1'b0, pop};
        if (push.valid) begin
            count_next = push.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            data0_reg <= push.data0;
            last0_reg <= push.last0;
            data1_reg <= push.data1;
            last1_reg <= push.last1;
        end else if (pop) begin
            // advance the second entry to the head
            data0_reg <= data1_reg;
            last0_reg <= last1_reg;
        end
    end

endmodule

// ----- design/additive_key_stream_cipher_core.sv -----
// ---------------------------------------------------------------------------
// additive_key_stream_cipher_core
// Byte cipher adding or subtracting a fixed, rolling or five-key shift.
// ---------------------------------------------------------------------------
// A byte is taken into an input register, shifted in one pass and written
// to a two-entry result buffer once that buffer has room; the result is
// offered from the buffer register. Bytes that give one result stream at
// one per cycle while the output is ready; in filler mode on encrypt, a byte
// that closes a group gives the data byte and a '*' filler, and the single
// output port of the result buffer sends them one after the other. A dropped
// filler on decrypt gives no result. Group position and key index restart
// after a byte marked last. Write the registers only while no request is in
// flight.
// ---------------------------------------------------------------------------
module additive_key_stream_cipher_core
    import akscp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              s_in_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_out_last
);

    cfg_t  cfg;
    push_t push;
    logic  room;

    akscp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    akscp_xform u_xform (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_in_last   (s_in_last),
        .room        (room),
        .push        (push)
    );

    akscp_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room       (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule

// ----- design/akscp_checker.sv -----
// ---------------------------------------------------------------------------
// akscp_checker
// Port-level checks of the cipher core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module akscp_checker
    import akscp_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              pready,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [BYTE_W-1:0] m_out_byte,
    input logic              m_out_last
);

    // a stalled result holds
    `AKSC_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_last), "result changed while stalled")

    // input stalls only behind a pending result
    `AKSC_ASSERT(a_stall_cause, aclk, aresetn, !s_ready |-> m_valid, "input stalled with empty result buffer")

    // a waiting request stays up until taken
    `AKSC_ASSERT(a_in_hold, aclk, aresetn, s_valid && !s_ready |=> s_valid, "request dropped before accept")

    `AKSC_ASSERT_ALWAYS(a_pready, aclk, pready, "pready dropped")

endmodule

bind additive_key_stream_cipher_core akscp_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .pready     (pready),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_out_last (m_out_last)
);

// ----- test/additive_key_stream_cipher_core_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// additive_key_stream_cipher_core_checker
// Watches the register port and both byte channels of the cipher core,
// tracks its configuration, group position and key index, works out the
// bytes that each request must give and compares them in order with the
// bytes that leave the core.
// ---------------------------------------------------------------------------
module additive_key_stream_cipher_core_checker
    import akscp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              s_in_last,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [BYTE_W-1:0] m_out_byte,
    input  logic              m_out_last,
    output int                mismatches,
    output int                pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } cipher_beat_t;

    cipher_beat_t      cipher_beats[$];
    cipher_beat_t      want;
    logic              have;

    mode_t             cfg_mode;
    logic              cfg_decrypt;
    logic [BYTE_W-1:0] cfg_shift;
    logic [BYTE_W-1:0] cfg_key [KEY_COUNT];

    logic [GP_W-1:0]   group_pos;
    logic [KIDX_W-1:0] key_idx;

    function automatic logic [BYTE_W-1:0] shift_byte(input logic [BYTE_W-1:0] b,
                                                     input logic [BYTE_W-1:0] s);
        return cfg_decrypt ? b - s : b + s;
    endfunction

    // Clamp a stale index from another mode, then advance it.
    function automatic logic [BYTE_W-1:0] take_key();
        logic [KIDX_W-1:0] idx;
        idx = (key_idx < KEY_COUNT) ? key_idx : KIDX_W'(KEY_COUNT - 1);
        key_idx = (idx + 1 >= KEY_COUNT) ? '0 : idx + 1'b1;
        return cfg_key[idx];
    endfunction

    function automatic logic [BYTE_W-1:0] take_roll();
        logic [KIDX_W-1:0] idx;
        idx = (key_idx < ROLL_TOP) ? key_idx : KIDX_W'(ROLL_TOP - 1);
        key_idx = (idx + 1 >= ROLL_TOP) ? '0 : idx + 1'b1;
        return BYTE_W'(idx) + 8'd1;
    endfunction

    task automatic cipher_byte(input logic [BYTE_W-1:0] b, input logic l);
        logic [BYTE_W-1:0] k;
        case (cfg_mode)
            MODE_FIXED: cipher_beats.push_back({shift_byte(b, cfg_shift), l});
            MODE_ROLL:  cipher_beats.push_back({shift_byte(b, take_roll()), l});
            MODE_KEYS:  cipher_beats.push_back({shift_byte(b, take_key()), l});
            default: begin
                if (!cfg_decrypt) begin
                    k = take_key();
                    if (group_pos + 1 >= GROUP_SIZE) begin
                        // close the group: the last mark moves to the filler
                        group_pos = '0;
                        cipher_beats.push_back({shift_byte(b, k), 1'b0});
                        cipher_beats.push_back({FILLER_BYTE, l});
                    end else begin
                        group_pos = group_pos + 1'b1;
                        cipher_beats.push_back({shift_byte(b, k), l});
                    end
                end else if (group_pos >= GROUP_SIZE) begin
                    // drop the filler, last mark included
                    group_pos = '0;
                end else begin
                    group_pos = group_pos + 1'b1;
                    cipher_beats.push_back({shift_byte(b, take_key()), l});
                end
            end
        endcase
        if (l) begin
            group_pos = '0;
            key_idx = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mode = MODE_FIXED;
            cfg_decrypt = 1'b0;
            cfg_shift = '0;
            foreach (cfg_key[i]) cfg_key[i] = '0;
            group_pos = '0;
            key_idx = '0;
            mismatches = 0;
            cipher_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                have = cipher_beats.size() != 0;
                if (have) want = cipher_beats.pop_front();
                if (!have || want.data !== m_out_byte || want.last !== m_out_last) begin
                    if (mismatches < 10) begin
                        if (have)
                            $display("%t mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                     $realtime, want.data, want.last, m_out_byte, m_out_last);
                        else
                            $display("%t unexpected result: byte %02h last %0b",
                                     $realtime, m_out_byte, m_out_last);
                    end
                    mismatches++;
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:2])
                    REG_MODE:    cfg_mode = mode_t'(pwdata[1:0]);
                    REG_DECRYPT: cfg_decrypt = pwdata[0];
                    REG_SHIFT:   cfg_shift = pwdata[BYTE_W-1:0];
                    default:     cfg_key[paddr[APB_AW-1:2] - REG_KEY0] = pwdata[BYTE_W-1:0];
                endcase
            end
            if (s_valid && s_ready) cipher_byte(s_data_byte, s_in_last);
        end
        pending <= cipher_beats.size();
    end

endmodule

// ----- test/additive_key_stream_cipher_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// additive_key_stream_cipher_core_test
// Drives the cipher core through a short directed set of messages in every
// mode, the key mode on encrypt only, then through random phases of random
// settings and messages, with idle cycles on both channels; the checker
// beside the core predicts and compares every output byte.
// ---------------------------------------------------------------------------
module additive_key_stream_cipher_core_test;
    import akscp_pkg::*;

    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int STALL_LIMIT    = 4000;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte = '0;
    logic              s_in_last   = 1'b0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_out_last;
    logic              steady      = 1'b0;

    int mismatches;
    int pending;
    int sent        = 0;
    int idle_cycles = 0;

    additive_key_stream_cipher_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last)
    );

    additive_key_stream_cipher_core_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 15);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("additive_key_stream_cipher_core verification failed");
                $finish;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // All tasks below start and end at a falling edge.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic config_phase(input mode_t m, input logic d, input logic [BYTE_W-1:0] sh,
                                input logic [KEY_COUNT*BYTE_W-1:0] keys);
        write_reg(REG_MODE, APB_DW'(m));
        write_reg(REG_DECRYPT, APB_DW'(d));
        write_reg(REG_SHIFT, APB_DW'(sh));
        for (int i = 0; i < KEY_COUNT; i++)
            write_reg(REG_IDX_W'(REG_KEY0 + i), APB_DW'(keys[BYTE_W*i +: BYTE_W]));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
        steady <= (sent >= 600 && sent < 800);
        if (!steady && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_in_last <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    // Hold off until every byte is out, then let a dropped filler clear the pipe.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic random_phase();
        mode_t                       m;
        logic                        d;
        logic [KEY_COUNT*BYTE_W-1:0] keys;
        int                          len;
        logic                        cut;
        logic [BYTE_W-1:0]           b;
        logic                        l;
        m = ($urandom_range(99) < 40) ? MODE_FILL : mode_t'($urandom_range(3));
        d = 1'($urandom_range(1));
        for (int i = 0; i < KEY_COUNT; i++) keys[BYTE_W*i +: BYTE_W] = pick_byte();
        drain();
        config_phase(m, d, pick_byte(), keys);
        repeat ($urandom_range(1, 6)) begin
            len = $urandom_range(1, 12);
            // a cut message carries its counters into the message after it
            cut = ($urandom_range(7) == 0);
            for (int j = 0; j < len; j++) begin
                l = (j == len - 1) && !cut;
                if ($urandom_range(9) == 0) l = 1'($urandom_range(1));
                b = BYTE_W'($urandom_range(255));
                if (m == MODE_FILL && d && j % (GROUP_SIZE + 1) == GROUP_SIZE) b = FILLER_BYTE;
                send_byte(b, l);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: fixed shift of zero
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
        config_phase(MODE_FIXED, 1'b1, 8'hFF, 40'h7F_00_80_FF_01);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
        config_phase(MODE_ROLL, 1'b0, 8'h00, 40'h7F_00_80_FF_01);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        // leave the key index at three, then roll from it
        drain();
        config_phase(MODE_KEYS, 1'b0, 8'h00, 40'h7F_00_80_FF_01);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h7F, 1'b0);
        drain();
        config_phase(MODE_ROLL, 1'b1, 8'h00, 40'h7F_00_80_FF_01);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // last byte closes a group
        drain();
        config_phase(MODE_FILL, 1'b0, 8'h00, 40'h7F_00_80_FF_01);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b1);
        // dropped filler marked last, then stop with the group full
        drain();
        config_phase(MODE_FILL, 1'b1, 8'h00, 40'h7F_00_80_FF_01);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(FILLER_BYTE, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        drain();
        config_phase(MODE_FILL, 1'b0, 8'h00, 40'h7F_00_80_FF_01);
        send_byte(8'h55, 1'b1);

        while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) random_phase();
        drain();

        if (mismatches == 0 && pending == 0)
            $display("additive_key_stream_cipher_core verification clean");
        else
            $display("additive_key_stream_cipher_core verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/akscp_pkg.sv
design/akscp_regs.sv
design/akscp_xform.sv
design/akscp_obuf.sv
design/additive_key_stream_cipher_core.sv
design/akscp_checker.sv
test/additive_key_stream_cipher_core_checker.sv
test/additive_key_stream_cipher_core_test.sv
